@@ design/bts_pkg.sv @@
// ============================================================================
// bts_pkg: shared types and constants for the block transfer sequencer
// Event codes, mode codes, controller/datapath interface structs and helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    // Result event codes
    localparam logic [1:0] EV_TRANSFER  = 2'd0;
    localparam logic [1:0] EV_UNDEF     = 2'd1;
    localparam logic [1:0] EV_WRITEBACK = 2'd2;
    localparam logic [1:0] EV_RESTORE   = 2'd3;

    // Mode field codes
    localparam logic [4:0] MODE_USER    = 5'h10;
    localparam logic [4:0] MODE_SYSTEM  = 5'h1F;

    // Controller -> datapath command word
    typedef struct packed {
        logic       load;      // capture instruction fields
        logic       setup;     // load start address and remaining list
        logic       step;      // retire lowest listed register, advance address
        logic       emit;      // drive a result word next cycle
        logic [1:0] kind;      // event code of the emitted word
        logic       last;      // final word of the instruction
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic undef;           // load with S in user or system mode
        logic wb;              // base write-back requested
        logic empty;           // register list is empty
        logic restore;         // SPSR copy follows the transfers
        logic rem_one;         // one register left to transfer
    } t_status;

    // Number of set bits in a register list
    function automatic logic [4:0] f_popcount(input logic [15:0] list);
        logic [4:0] cnt;
        cnt = '0;
        for (int i = 0; i < 16; i++) begin
            cnt = cnt + {4'd0, list[i]};
        end
        return cnt;
    endfunction

    // Index of the lowest set bit (0 when none is set)
    function automatic logic [3:0] f_lowest(input logic [15:0] list);
        logic [3:0] idx;
        idx = '0;
        for (int i = 15; i >= 0; i--) begin
            if (list[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ design/bts_datapath.sv @@
// ============================================================================
// bts_datapath: address generation and result registers
// Holds the instruction, walks the register list and drives the result word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bts_datapath
    import bts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [15:0] i_reg_list,
    input  wire logic        i_pre_index,
    input  wire logic        i_up_dir,
    input  wire logic        i_s_flag,
    input  wire logic        i_write_back,
    input  wire logic        i_is_load_op,
    input  wire logic [3:0]  i_base_reg,
    input  wire logic [31:0] i_base_value,
    input  wire logic [4:0]  i_cpu_mode,
    output logic             o_valid,
    output logic [1:0]       o_event_kind,
    output logic [31:0]      o_address,
    output logic [3:0]       o_reg_index,
    output logic             o_load_dir,
    output logic             o_user_bank,
    output logic             o_last
);

    // Captured instruction
    logic [15:0] r_list;
    logic        r_p, r_u, r_s, r_w, r_l;
    logic [3:0]  r_rn;
    logic [31:0] r_base;
    logic [4:0]  r_mode;

    // Walk state
    logic [15:0] r_rem, n_rem;
    logic [31:0] r_addr, n_addr;

    // Derived values
    logic [4:0]  count;
    logic [31:0] span;
    logic [31:0] start_addr;
    logic [31:0] wb_value;
    logic        priv;
    logic        ubank;
    logic [3:0]  low_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_list <= i_reg_list;
            r_p    <= i_pre_index;
            r_u    <= i_up_dir;
            r_s    <= i_s_flag;
            r_w    <= i_write_back;
            r_l    <= i_is_load_op;
            r_rn   <= i_base_reg;
            r_base <= i_base_value;
            r_mode <= i_cpu_mode;
        end
    end

    // Addressing mode start and write-back value
    always_comb begin
        count = f_popcount(r_list);
        span  = {25'd0, count, 2'b00};
        if (r_u) begin
            start_addr = r_p ? r_base + 32'd4 : r_base;
            wb_value   = r_base + span;
        end else begin
            start_addr = r_p ? r_base - span : r_base - span + 32'd4;
            wb_value   = r_base - span;
        end
        priv  = (r_mode != MODE_USER);
        ubank = r_l ? (r_s && !r_list[15] && priv) : (r_s && priv);
    end

    assign low_idx = f_lowest(r_rem);

    // Status to controller
    always_comb begin
        o_status.undef   = r_l && r_s && ((r_mode == MODE_USER) || (r_mode == MODE_SYSTEM));
        o_status.wb      = r_w;
        o_status.empty   = (r_list == 16'd0);
        o_status.restore = r_l && r_s && r_list[15];
        o_status.rem_one = ((r_rem & (r_rem - 16'd1)) == 16'd0);
    end

    // List walk
    always_comb begin
        n_rem  = r_rem;
        n_addr = r_addr;
        if (i_cmd.setup) begin
            n_rem  = r_list;
            n_addr = start_addr;
        end else if (i_cmd.step) begin
            n_rem  = r_rem & (r_rem - 16'd1);
            n_addr = r_addr + 32'd4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_addr <= n_addr;
    end

    // Result word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_event_kind <= i_cmd.kind;
            o_last       <= i_cmd.last;
            case (i_cmd.kind)
                EV_TRANSFER: begin
                    o_address   <= r_addr;
                    o_reg_index <= low_idx;
                    o_load_dir  <= r_l;
                    o_user_bank <= ubank;
                end
                EV_WRITEBACK: begin
                    o_address   <= wb_value;
                    o_reg_index <= r_rn;
                    o_load_dir  <= 1'b0;
                    o_user_bank <= 1'b0;
                end
                default: begin
                    o_address   <= 32'd0;
                    o_reg_index <= 4'd0;
                    o_load_dir  <= 1'b0;
                    o_user_bank <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/bts_ctrl.sv @@
// ============================================================================
// bts_ctrl: sequencing state machine
// Orders the undefined, write-back, transfer and restore words.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bts_ctrl
    import bts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_XFER  = 2'd2;
    localparam logic [1:0] ST_REST  = 2'd3;

    logic [1:0] r_state, n_state;

    assign busy = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.kind   = EV_TRANSFER;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_status.undef) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = EV_UNDEF;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    if (i_status.wb) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = EV_WRITEBACK;
                        o_cmd.last = i_status.empty;
                    end
                    n_state = i_status.empty ? ST_IDLE : ST_XFER;
                end
            end
            ST_XFER: begin
                o_cmd.step = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.kind = EV_TRANSFER;
                o_cmd.last = i_status.rem_one && !i_status.restore;
                if (i_status.rem_one) begin
                    n_state = i_status.restore ? ST_REST : ST_IDLE;
                end
            end
            ST_REST: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EV_RESTORE;
                o_cmd.last = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/block_transfer_sequencer.sv @@
// ============================================================================
// block_transfer_sequencer: load/store multiple expansion
// Expands one block-transfer instruction into a run of result words.
// ============================================================================
// Usage:
//   Input: drive the instruction fields and raise start; the word is taken at
//   a clock edge with start high and busy low. busy stays high until the last
//   result word has been decided.
//   Output: each result word sits on the o_ ports for one cycle with o_valid
//   high; o_last marks the final word. The receiver cannot stall, so words
//   simply follow one per cycle.
//   Order: undefined event alone, or write-back, then one transfer per listed
//   register (lowest first), then the SPSR restore when it applies.
//   Timing: the accepting edge captures the fields and enters setup; an
//   undefined or write-back word is decided in setup and registered onto the
//   outputs; a run that opens with a transfer waits for the transfer state.
//   Throughput: busy stays high through setup, one transfer state per listed
//   register and the restore state when it applies (setup alone for the
//   undefined case), so a new instruction is taken only after the sequencer
//   has returned to idle; the list walk retires one register per cycle.
//   An empty list without write-back yields no word at all, unless the load is undefined.
//   Reset: synchronous, active low; returns the sequencer to idle and drops
//   o_valid. No other state needs clearing.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module block_transfer_sequencer
    import bts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_reg_list,
    input  wire logic        i_pre_index,
    input  wire logic        i_up_dir,
    input  wire logic        i_s_flag,
    input  wire logic        i_write_back,
    input  wire logic        i_is_load_op,
    input  wire logic [3:0]  i_base_reg,
    input  wire logic [31:0] i_base_value,
    input  wire logic [4:0]  i_cpu_mode,
    output logic             o_valid,
    output logic [1:0]       o_event_kind,
    output logic [31:0]      o_address,
    output logic [3:0]       o_reg_index,
    output logic             o_load_dir,
    output logic             o_user_bank,
    output logic             o_last
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    bts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Address and result datapath
    bts_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_reg_list   (i_reg_list),
        .i_pre_index  (i_pre_index),
        .i_up_dir     (i_up_dir),
        .i_s_flag     (i_s_flag),
        .i_write_back (i_write_back),
        .i_is_load_op (i_is_load_op),
        .i_base_reg   (i_base_reg),
        .i_base_value (i_base_value),
        .i_cpu_mode   (i_cpu_mode),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_address    (o_address),
        .o_reg_index  (o_reg_index),
        .o_load_dir   (o_load_dir),
        .o_user_bank  (o_user_bank),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
